>>> rtl/spcp_pkg.sv
package spcp_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 63;

  localparam logic [CfgIdxW-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CONTACT  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LIN_VEL  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ANG_VEL  = 3'd5;

  // Datapath sizing
  localparam int unsigned RadW     = 46;  // squared distance while in contact
  localparam int unsigned SqrtBits = 23;  // root bits, one per stage
  localparam int unsigned QuotBits = 24;  // quotient bits, one per stage
  localparam int unsigned NumW     = 48;  // dividend width
  localparam int unsigned Lanes    = 6;   // three normal and three offset quotients

  localparam logic [17:0] NORMAL_ONE = 18'd65536;

  typedef struct packed {
    logic [23:0] pos_z;
    logic [23:0] pos_y;
    logic [23:0] pos_x;
    logic [23:0] vel_z;
    logic [23:0] vel_y;
    logic [23:0] vel_x;
  } in_item_t;

  typedef struct packed {
    logic [23:0] new_pos_z;
    logic [23:0] new_pos_y;
    logic [23:0] new_pos_x;
    logic [23:0] new_vel_z;
    logic [23:0] new_vel_y;
    logic [23:0] new_vel_x;
    logic        contact_hit;
  } out_item_t;

  typedef struct packed {
    logic [2:0][23:0] center;
    logic [22:0]      cd;
    logic [62:0]      lin;
    logic [62:0]      ang;
  } cfg_t;

  // Sideband through the square root pipe
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [2:0][23:0] pos;
    logic [2:0][23:0] vel;
    logic [2:0]       dneg;
    logic [2:0][23:0] dmag;
    logic [2:0][46:0] dcd;
  } sq_side_t;

  // Sideband through the divider pipe
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             zero;
    logic [2:0][23:0] pos;
    logic [2:0][23:0] vel;
    logic [2:0]       dneg;
  } dv_side_t;

  // Round to nearest on a 16-bit right shift, ties away from zero
  function automatic logic signed [63:0] shr_round16(input logic signed [63:0] x);
    logic [63:0] mag;
    mag = x[63] ? 64'(-x) : 64'(x);
    mag = (mag + 64'd32768) >> 16;
    return x[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [23:0] sat24(input logic signed [63:0] x);
    logic [23:0] res;
    if (x > 64'sd8388607) begin
      res = 24'h7FFFFF;
    end else if (x < -64'sd8388608) begin
      res = 24'h800000;
    end else begin
      res = x[23:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/spcp_in_if.sv
interface spcp_in_if import spcp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/spcp_out_if.sv
interface spcp_out_if import spcp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/spcp_front.sv
module spcp_front import spcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  in_item_t    item_i,
  input  cfg_t        cfg_i,
  output sq_side_t    side_o,
  output logic [RadW-1:0] rad_o
);

  logic [2:0][23:0] pos_w, vel_w, dmag_w;
  logic [2:0][24:0] diff_w;
  logic [2:0]       dneg_w;

  assign pos_w = {item_i.pos_z, item_i.pos_y, item_i.pos_x};
  assign vel_w = {item_i.vel_z, item_i.vel_y, item_i.vel_x};

  // Offset from the centre, split into sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_w[i] = {pos_w[i][23], pos_w[i]} - {cfg_i.center[i][23], cfg_i.center[i]};
      dneg_w[i] = diff_w[i][24];
      dmag_w[i] = dneg_w[i] ? 24'(-diff_w[i]) : diff_w[i][23:0];
    end
  end

  logic             va_q, vb_q, vc_q;
  logic [2:0][23:0] pos_a_q, vel_a_q, dmag_a_q;
  logic [2:0]       dneg_a_q;
  logic [2:0][23:0] pos_b_q, vel_b_q, dmag_b_q;
  logic [2:0]       dneg_b_q;
  logic [2:0][47:0] sq_b_q;
  logic [2:0][46:0] dcd_b_q;
  logic [45:0]      cdsq_q;
  logic [49:0]      dist2_d, dist2_q;
  sq_side_t         side_q;

  // Contact distance squared, follows the register
  always_ff @(posedge clk_i) begin
    cdsq_q <= cfg_i.cd * cfg_i.cd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  assign dist2_d = {2'b0, sq_b_q[0]} + {2'b0, sq_b_q[1]} + {2'b0, sq_b_q[2]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // offsets
      pos_a_q  <= pos_w;
      vel_a_q  <= vel_w;
      dmag_a_q <= dmag_w;
      dneg_a_q <= dneg_w;
      // squares and offset times contact distance
      pos_b_q  <= pos_a_q;
      vel_b_q  <= vel_a_q;
      dmag_b_q <= dmag_a_q;
      dneg_b_q <= dneg_a_q;
      for (int i = 0; i < 3; i++) begin
        sq_b_q[i]  <= dmag_a_q[i] * dmag_a_q[i];
        dcd_b_q[i] <= dmag_a_q[i] * cfg_i.cd;
      end
      // sum and contact test
      dist2_q     <= dist2_d;
      side_q.hit  <= dist2_d < {4'b0, cdsq_q};
      side_q.pos  <= pos_b_q;
      side_q.vel  <= vel_b_q;
      side_q.dneg <= dneg_b_q;
      side_q.dmag <= dmag_b_q;
      side_q.dcd  <= dcd_b_q;
    end
  end

  always_comb begin
    side_o       = side_q;
    side_o.valid = vc_q;
  end

  assign side_q.valid = 1'b0;
  assign rad_o = dist2_q[RadW-1:0];

  // In contact the squared distance is below the contact distance squared
  a_hit_fits_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q && side_q.hit |-> dist2_q[49:RadW] == '0)
    else $error("hit with squared distance beyond root range");

endmodule

>>> rtl/spcp_sqrt.sv
module spcp_sqrt import spcp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  sq_side_t            side_i,
  input  logic [RadW-1:0]     rad_i,
  output sq_side_t            side_o,
  output logic [SqrtBits-1:0] root_o
);

  logic [47:0]         rem_w  [SqrtBits+1];
  logic [SqrtBits-1:0] res_w  [SqrtBits+1];
  sq_side_t            side_w [SqrtBits+1];

  assign rem_w[0]  = {2'b0, rad_i};
  assign res_w[0]  = '0;
  assign side_w[0] = side_i;

  // One root bit per stage, remainder kept as radicand minus root squared
  for (genvar s = 0; s < SqrtBits; s++) begin : g_stage
    localparam int unsigned B = SqrtBits - 1 - s;
    logic [47:0]         trial;
    logic                take;
    logic [47:0]         rem_q;
    logic [SqrtBits-1:0] res_q;
    sq_side_t            side_q;

    assign trial = (48'(res_w[s]) << (B + 1)) + (48'd1 << (2 * B));
    assign take  = rem_w[s] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q <= '0;
      end else if (en_i) begin
        side_q <= side_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= take ? rem_w[s] - trial : rem_w[s];
        res_q <= take ? res_w[s] | (SqrtBits'(1) << B) : res_w[s];
      end
    end

    assign rem_w[s+1]  = rem_q;
    assign res_w[s+1]  = res_q;
    assign side_w[s+1] = side_q;
  end

  assign side_o = side_w[SqrtBits];
  assign root_o = res_w[SqrtBits];

  // Floor root: what is left never exceeds twice the root
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_o.valid |-> rem_w[SqrtBits] <= {24'b0, res_w[SqrtBits], 1'b0})
    else $error("square root remainder out of range");

endmodule

>>> rtl/spcp_div.sv
module spcp_div import spcp_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  sq_side_t                       side_i,
  input  logic [SqrtBits-1:0]            root_i,
  output dv_side_t                       side_o,
  output logic [2:0][QuotBits-1:0]       quot_n_o,
  output logic [2:0][QuotBits-1:0]       quot_p_o
);

  // Dividends with half the divisor added for rounding
  logic [Lanes-1:0][NumW-1:0] num_d;
  logic [NumW-1:0]            half_w;

  assign half_w = {26'b0, root_i[SqrtBits-1:1]};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i]     = {8'b0, side_i.dmag[i], 16'b0} + half_w;
      num_d[3 + i] = {1'b0, side_i.dcd[i]} + half_w;
    end
  end

  dv_side_t                     side0_q;
  logic [SqrtBits-1:0]          den0_q;
  logic [Lanes-1:0][NumW-1:0]   num0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side0_q <= '0;
    end else if (en_i) begin
      side0_q.valid <= side_i.valid;
      side0_q.hit   <= side_i.hit;
      side0_q.zero  <= root_i == '0;
      side0_q.pos   <= side_i.pos;
      side0_q.vel   <= side_i.vel;
      side0_q.dneg  <= side_i.dneg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den0_q <= root_i;
      num0_q <= num_d;
    end
  end

  logic [Lanes-1:0][NumW-1:0]     rem_w  [QuotBits+1];
  logic [Lanes-1:0][QuotBits-1:0] quo_w  [QuotBits+1];
  logic [SqrtBits-1:0]            den_w  [QuotBits+1];
  dv_side_t                       side_w [QuotBits+1];

  assign rem_w[0]  = num0_q;
  assign quo_w[0]  = '0;
  assign den_w[0]  = den0_q;
  assign side_w[0] = side0_q;

  // Restoring division, one quotient bit per stage for all lanes
  for (genvar s = 0; s < QuotBits; s++) begin : g_stage
    localparam int unsigned K = QuotBits - 1 - s;
    logic [NumW-1:0]                trial;
    logic [Lanes-1:0][NumW-1:0]     rem_d;
    logic [Lanes-1:0][QuotBits-1:0] quo_d;
    logic [Lanes-1:0][NumW-1:0]     rem_q;
    logic [Lanes-1:0][QuotBits-1:0] quo_q;
    logic [SqrtBits-1:0]            den_q;
    dv_side_t                       side_q;

    assign trial = NumW'(den_w[s]) << K;

    always_comb begin
      for (int l = 0; l < Lanes; l++) begin
        if (rem_w[s][l] >= trial) begin
          rem_d[l] = rem_w[s][l] - trial;
          quo_d[l] = quo_w[s][l] | (QuotBits'(1) << K);
        end else begin
          rem_d[l] = rem_w[s][l];
          quo_d[l] = quo_w[s][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q <= '0;
      end else if (en_i) begin
        side_q <= side_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        den_q <= den_w[s];
      end
    end

    assign rem_w[s+1]  = rem_q;
    assign quo_w[s+1]  = quo_q;
    assign den_w[s+1]  = den_q;
    assign side_w[s+1] = side_q;
  end

  assign side_o = side_w[QuotBits];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quot_n_o[i] = quo_w[QuotBits][i];
      quot_p_o[i] = quo_w[QuotBits][3 + i];
    end
  end

  // Unit normal components never exceed one
  a_normal_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_o.valid && side_o.hit && !side_o.zero |->
      quot_n_o[0] <= 24'd65536 && quot_n_o[1] <= 24'd65536 && quot_n_o[2] <= 24'd65536)
    else $error("normal component above one");

endmodule

>>> rtl/spcp_resp.sv
module spcp_resp import spcp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  cfg_t                     cfg_i,
  input  dv_side_t                 side_i,
  input  logic [2:0][QuotBits-1:0] quot_n_i,
  input  logic [2:0][QuotBits-1:0] quot_p_i,
  output logic                     valid_o,
  output out_item_t                item_o
);

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [2:0][23:0] pos;
    logic [2:0][23:0] vel;
    logic [2:0][23:0] p;
    logic [2:0][17:0] n;
  } rp_t;

  // Normal, projected position and lever arm
  rp_t              rp_d;
  logic [2:0][24:0] off_w;
  logic [2:0][25:0] psum_w;
  logic [2:0][24:0] r_d;

  always_comb begin
    rp_d.valid = side_i.valid;
    rp_d.hit   = side_i.hit;
    rp_d.pos   = side_i.pos;
    rp_d.vel   = side_i.vel;
    for (int i = 0; i < 3; i++) begin
      if (side_i.zero) begin
        rp_d.n[i] = (i == 1) ? NORMAL_ONE : 18'd0;
        off_w[i]  = (i == 1) ? {2'b0, cfg_i.cd} : 25'd0;
      end else begin
        rp_d.n[i] = side_i.dneg[i] ? -{1'b0, quot_n_i[i][16:0]} : {1'b0, quot_n_i[i][16:0]};
        off_w[i]  = side_i.dneg[i] ? -{1'b0, quot_p_i[i]} : {1'b0, quot_p_i[i]};
      end
      psum_w[i]  = {{2{cfg_i.center[i][23]}}, cfg_i.center[i]} + {off_w[i][24], off_w[i]};
      rp_d.p[i]  = sat24(64'($signed(psum_w[i])));
      r_d[i]     = {rp_d.p[i][23], rp_d.p[i]} - {cfg_i.center[i][23], cfg_i.center[i]};
    end
  end

  rp_t              rp_q [6];
  logic [2:0][24:0] r_q;
  logic [5:0][45:0] wr_q;
  logic [2:0][33:0] rel_q;
  logic [2:0][51:0] rn_q;
  logic [37:0]      inward_q;
  logic [2:0][55:0] inn_q;
  logic             inneg_q;
  logic             out_valid_q;
  out_item_t        out_q;

  // Cross product terms and relative velocity
  logic signed [63:0] cross_w [3];
  logic signed [63:0] rel_w   [3];
  logic signed [63:0] dot_w;
  logic signed [63:0] inward_w;
  logic [2:0][23:0]   vnew_w;
  logic [20:0]        w_c [3];
  logic [20:0]        v_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_c[i] = cfg_i.ang[21*i +: 21];
      v_c[i] = cfg_i.lin[21*i +: 21];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cross_w[i] = 64'($signed(wr_q[2*i])) - 64'($signed(wr_q[2*i+1]));
      rel_w[i]   = 64'($signed(rp_q[1].vel[i]))
                   - (64'($signed(v_c[i])) + shr_round16(cross_w[i]));
    end
    dot_w    = 64'($signed(rn_q[0])) + 64'($signed(rn_q[1])) + 64'($signed(rn_q[2]));
    inward_w = shr_round16(dot_w);
    for (int i = 0; i < 3; i++) begin
      vnew_w[i] = inneg_q
        ? sat24(64'($signed(rp_q[5].vel[i])) - shr_round16(64'($signed(inn_q[i]))))
        : rp_q[5].vel[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) begin
        rp_q[k] <= '0;
      end
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      rp_q[0] <= rp_d;
      for (int k = 1; k < 6; k++) begin
        rp_q[k] <= rp_q[k-1];
      end
      out_valid_q <= rp_q[5].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
      // w x r partial products
      wr_q[0] <= $signed(w_c[1]) * $signed(r_q[2]);
      wr_q[1] <= $signed(w_c[2]) * $signed(r_q[1]);
      wr_q[2] <= $signed(w_c[2]) * $signed(r_q[0]);
      wr_q[3] <= $signed(w_c[0]) * $signed(r_q[2]);
      wr_q[4] <= $signed(w_c[0]) * $signed(r_q[1]);
      wr_q[5] <= $signed(w_c[1]) * $signed(r_q[0]);
      for (int i = 0; i < 3; i++) begin
        rel_q[i] <= rel_w[i][33:0];
        rn_q[i]  <= $signed(rel_q[i]) * $signed(rp_q[2].n[i]);
        inn_q[i] <= $signed(inward_q) * $signed(rp_q[4].n[i]);
      end
      inward_q <= inward_w[37:0];
      inneg_q  <= inward_q[37];
      // output register
      if (rp_q[5].hit) begin
        out_q.new_pos_x <= rp_q[5].p[0];
        out_q.new_pos_y <= rp_q[5].p[1];
        out_q.new_pos_z <= rp_q[5].p[2];
        out_q.new_vel_x <= vnew_w[0];
        out_q.new_vel_y <= vnew_w[1];
        out_q.new_vel_z <= vnew_w[2];
      end else begin
        out_q.new_pos_x <= rp_q[5].pos[0];
        out_q.new_pos_y <= rp_q[5].pos[1];
        out_q.new_pos_z <= rp_q[5].pos[2];
        out_q.new_vel_x <= rp_q[5].vel[0];
        out_q.new_vel_y <= rp_q[5].vel[1];
        out_q.new_vel_z <= rp_q[5].vel[2];
      end
      out_q.contact_hit <= rp_q[5].hit;
    end
  end

  assign valid_o = out_valid_q;
  assign item_o  = out_q;

endmodule

>>> rtl/sphere_particle_contact_projection_core.sv
// Sphere / particle contact projection.
// in_i takes one request per cycle unless stalled (position, velocity, Q7.16);
// out_o returns one result per request in order: the position pushed onto the
// contact surface and the velocity with its inward part (relative to the
// sphere surface) removed, or the particle unchanged with contact_hit low.
// The sphere (centre, contact distance, linear and angular velocity) is set
// through the cfg_* write port, registers 0..5. The user must write them only
// while no request is in flight; the block does not enforce it. The pipe holds
// the offset and distance test stages, 23 square root stages (one root bit
// each), 25 divider stages (dividend set-up plus one quotient bit each) and 7
// response stages with the cross and dot products. Throughput is one request
// per cycle. Reset empties the pipe and clears all sphere registers to zero.
// When the receiver holds out_o.ready low with a result waiting, the whole
// pipe freezes and in_i.ready drops; nothing is lost or repeated.
module sphere_particle_contact_projection_core import spcp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  spcp_in_if.sink             in_i,
  spcp_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic en;

  // Sphere registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_CENTER_X: cfg_q.center[0] <= cfg_wdata_i[23:0];
        CFG_CENTER_Y: cfg_q.center[1] <= cfg_wdata_i[23:0];
        CFG_CENTER_Z: cfg_q.center[2] <= cfg_wdata_i[23:0];
        CFG_CONTACT:  cfg_q.cd        <= cfg_wdata_i[22:0];
        CFG_LIN_VEL:  cfg_q.lin       <= cfg_wdata_i;
        CFG_ANG_VEL:  cfg_q.ang       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipe advances unless a result is held at the output
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  sq_side_t                 fr_side, sq_side;
  logic [RadW-1:0]          rad;
  logic [SqrtBits-1:0]      root;
  dv_side_t                 dv_side;
  logic [2:0][QuotBits-1:0] quot_n, quot_p;

  spcp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_i.valid),
    .item_i (in_i.payload),
    .cfg_i  (cfg_q),
    .side_o (fr_side),
    .rad_o  (rad)
  );

  spcp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (fr_side),
    .rad_i  (rad),
    .side_o (sq_side),
    .root_o (root)
  );

  spcp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .side_i  (sq_side),
    .root_i  (root),
    .side_o  (dv_side),
    .quot_n_o(quot_n),
    .quot_p_o(quot_p)
  );

  spcp_resp u_resp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .side_i  (dv_side),
    .quot_n_i(quot_n),
    .quot_p_i(quot_p),
    .valid_o (out_o.valid),
    .item_o  (out_o.payload)
  );

  // A zero contact distance can never report contact
  a_no_hit_zero_cd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.payload.contact_hit && cfg_q.cd == '0))
    else $error("contact reported with zero contact distance");

endmodule

>>> test/sphere_particle_contact_projection_core_test.sv
`timescale 1ns / 1ps

module sphere_particle_contact_projection_core_test;
  import spcp_pkg::*;

  localparam int unsigned DrainCycles = 70;
  localparam longint     S24Max      = 8388607;
  localparam longint     S24Min      = -8388608;

  logic clk_i;
  logic rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  spcp_in_if  in_ch ();
  spcp_out_if out_ch ();

  sphere_particle_contact_projection_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // sphere as the predictor sees it
  longint       sph_centre [3];
  longint       sph_contact;
  logic [62:0]  sph_lin;
  logic [62:0]  sph_ang;

  out_item_t contact_q [$];   // expected results, oldest first
  bit        known_q [$];     // per sent request: result typed in
  out_item_t typed_q [$];
  int        errors;
  bit        calm;            // no idling on either side

  function automatic longint sx24(logic [23:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint sx21(logic [20:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clamp24(longint x);
    if (x > S24Max) return S24Max;
    if (x < S24Min) return S24Min;
    return x;
  endfunction

  // round to nearest on a 16-bit shift, ties away from zero
  function automatic longint rshift16(longint x);
    if (x >= 0) return (x + 32768) >>> 16;
    return -((-x + 32768) >>> 16);
  endfunction

  function automatic longint rdiv(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint root_floor(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  // projected particle for one request
  function automatic out_item_t project_particle(in_item_t it);
    longint p [3], v [3], d [3], n [3], r [3], lv [3], av [3], rel [3];
    longint dist2, rlen, inward;
    out_item_t o;
    p[0] = sx24(it.pos_x); p[1] = sx24(it.pos_y); p[2] = sx24(it.pos_z);
    v[0] = sx24(it.vel_x); v[1] = sx24(it.vel_y); v[2] = sx24(it.vel_z);
    dist2 = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = p[i] - sph_centre[i];
      dist2 += d[i] * d[i];
    end
    o.contact_hit = 1'b0;
    if (dist2 < sph_contact * sph_contact) begin
      o.contact_hit = 1'b1;
      rlen = root_floor(dist2);
      if (rlen == 0) begin
        // centred particle: normal is +Y
        n[0] = 0; n[1] = 65536; n[2] = 0;
        p[0] = sph_centre[0];
        p[1] = clamp24(sph_centre[1] + sph_contact);
        p[2] = sph_centre[2];
      end else begin
        for (int i = 0; i < 3; i++) begin
          n[i] = rdiv(d[i] * 65536, rlen);
          p[i] = clamp24(sph_centre[i] + rdiv(d[i] * sph_contact, rlen));
        end
      end
      for (int i = 0; i < 3; i++) begin
        r[i]  = p[i] - sph_centre[i];
        lv[i] = sx21(sph_lin[21*i +: 21]);
        av[i] = sx21(sph_ang[21*i +: 21]);
      end
      rel[0] = v[0] - (lv[0] + rshift16(av[1] * r[2] - av[2] * r[1]));
      rel[1] = v[1] - (lv[1] + rshift16(av[2] * r[0] - av[0] * r[2]));
      rel[2] = v[2] - (lv[2] + rshift16(av[0] * r[1] - av[1] * r[0]));
      inward = rshift16(rel[0] * n[0] + rel[1] * n[1] + rel[2] * n[2]);
      if (inward < 0) begin
        for (int i = 0; i < 3; i++) v[i] = clamp24(v[i] - rshift16(inward * n[i]));
      end
    end
    o.new_pos_x = p[0][23:0]; o.new_pos_y = p[1][23:0]; o.new_pos_z = p[2][23:0];
    o.new_vel_x = v[0][23:0]; o.new_vel_y = v[1][23:0]; o.new_vel_z = v[2][23:0];
    return o;
  endfunction

  // request accepted: queue what it must give
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      if (known_q.size() != 0 && known_q[0]) contact_q.push_back(typed_q[0]);
      else contact_q.push_back(project_particle(in_ch.payload));
      if (known_q.size() != 0) begin
        void'(known_q.pop_front());
        void'(typed_q.pop_front());
      end
    end
  end

  // result accepted: compare with the oldest expectation
  always @(posedge clk_i) begin
    logic [144:0] e, a;
    string names [6];
    names = '{"new_vel_x", "new_vel_y", "new_vel_z", "new_pos_x", "new_pos_y", "new_pos_z"};
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (contact_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_ch.payload);
        errors++;
      end else begin
        e = contact_q.pop_front();
        a = out_ch.payload;
        for (int k = 0; k < 6; k++) begin
          if (e[24*k+1 +: 24] !== a[24*k+1 +: 24]) begin
            $display("%0t: %s expected %h actual %h", $time, names[k],
                     e[24*k+1 +: 24], a[24*k+1 +: 24]);
            errors++;
          end
        end
        if (e[0] !== a[0]) begin
          $display("%0t: contact_hit expected %b actual %b", $time, e[0], a[0]);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 9);
  end

  task automatic send_particle(in_item_t it, bit known, out_item_t exp);
    known_q.push_back(known);
    typed_q.push_back(exp);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // wait until every request has come back, then let the pipe empty
  task automatic drain_pipe();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    wait (contact_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CENTER_X: sph_centre[0] = sx24(val[23:0]);
      CFG_CENTER_Y: sph_centre[1] = sx24(val[23:0]);
      CFG_CENTER_Z: sph_centre[2] = sx24(val[23:0]);
      CFG_CONTACT:  sph_contact   = longint'(val[22:0]);
      CFG_LIN_VEL:  sph_lin       = val;
      CFG_ANG_VEL:  sph_ang       = val;
      default: ;
    endcase
  endtask

  task automatic set_sphere(logic [23:0] cx, logic [23:0] cy, logic [23:0] cz,
                            logic [22:0] cd, logic [62:0] lin, logic [62:0] ang);
    cfg_write(CFG_CENTER_X, 63'(cx));
    cfg_write(CFG_CENTER_Y, 63'(cy));
    cfg_write(CFG_CENTER_Z, 63'(cz));
    cfg_write(CFG_CONTACT, 63'(cd));
    cfg_write(CFG_LIN_VEL, lin);
    cfg_write(CFG_ANG_VEL, ang);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [62:0] rand63();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [23:0] rand_vel();
    if ($urandom_range(1)) return 24'($signed($urandom_range(262143)) - 131072);
    return 24'($urandom());
  endfunction

  // mostly near the sphere, some at its centre, some anywhere
  function automatic in_item_t rand_particle();
    in_item_t it;
    longint span, c [3];
    int unsigned roll;
    longint off;
    c[0] = sph_centre[0]; c[1] = sph_centre[1]; c[2] = sph_centre[2];
    span = sph_contact + sph_contact / 4 + 2;
    if (span > 32'h3FFFFFFF) span = 32'h3FFFFFFF;
    roll = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      off = longint'($urandom_range(32'(2 * span))) - span;
      if (roll < 70) c[i] = c[i] + off;
      else if (roll >= 80) c[i] = longint'($signed(24'($urandom())));
      if (i == 0) it.pos_x = c[i][23:0];
      if (i == 1) it.pos_y = c[i][23:0];
      if (i == 2) it.pos_z = c[i][23:0];
    end
    it.vel_x = rand_vel();
    it.vel_y = rand_vel();
    it.vel_z = rand_vel();
    return it;
  endfunction

  typedef struct {
    int        phase;
    in_item_t  item;
    bit        known;
    out_item_t exp;
  } stim_row_t;

  function automatic out_item_t unchanged(in_item_t it);
    out_item_t o;
    o = {it.pos_z, it.pos_y, it.pos_x, it.vel_z, it.vel_y, it.vel_x, 1'b0};
    return o;
  endfunction

  function automatic in_item_t mk(logic [23:0] px, logic [23:0] py, logic [23:0] pz,
                                  logic [23:0] vx, logic [23:0] vy, logic [23:0] vz);
    in_item_t it;
    it = {pz, py, px, vz, vy, vx};
    return it;
  endfunction

  stim_row_t stim [$];

  initial begin
    in_item_t  it;
    out_item_t o;
    int        cur_phase;
    errors = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    sph_centre[0] = 0; sph_centre[1] = 0; sph_centre[2] = 0;
    sph_contact = 0; sph_lin = '0; sph_ang = '0;

    // after reset the contact distance is zero: everything passes
    it = mk(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    stim.push_back('{0, it, 1, unchanged(it)});
    it = mk(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
    stim.push_back('{0, it, 1, unchanged(it)});
    it = '0;
    stim.push_back('{0, it, 1, unchanged(it)});
    it = mk(24'hFFFFFF, 24'h000001, 24'h555555, 24'hAAAAAA, 24'h123456, 24'hFEDCBA);
    stim.push_back('{0, it, 1, unchanged(it)});
    // sphere at (1, -2, 0.5), contact 2, at rest
    it = mk(24'h010000, 24'hFE0000, 24'h008000, 24'h0, 24'h0, 24'h0);
    o = {24'h008000, 24'h000000, 24'h010000, 24'h0, 24'h0, 24'h0, 1'b1};
    stim.push_back('{1, it, 1, o});     // centred particle
    it = mk(24'h030000, 24'hFE0000, 24'h008000, 24'h012345, 24'h0, 24'h0);
    stim.push_back('{1, it, 1, unchanged(it)});  // exactly on the surface
    it = mk(24'h010000, 24'hFE0000, 24'h038000, 24'h0, 24'h0, 24'hFF0000);
    stim.push_back('{1, it, 1, unchanged(it)});  // outside
    it = mk(24'h010000, 24'hFE0000, 24'h008000, 24'h0, 24'hFF0000, 24'h0);
    stim.push_back('{1, it, 0, o});     // centred, moving in
    it = mk(24'h018000, 24'hFE0000, 24'h008000, 24'hFF0000, 24'h000100, 24'h0);
    stim.push_back('{1, it, 0, o});     // inside, moving in
    it = mk(24'h018000, 24'hFE8000, 24'h00C000, 24'h010000, 24'h0, 24'h0);
    stim.push_back('{1, it, 0, o});     // inside, moving out
    it = mk(24'h010001, 24'hFE0000, 24'h008000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    stim.push_back('{1, it, 0, o});
    // largest sphere at the top corner: saturation
    it = mk(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000);
    stim.push_back('{2, it, 0, o});
    it = mk(24'h7FFFF0, 24'h7F0000, 24'h7FFFFF, 24'h7FFFFF, 24'h0, 24'h800000);
    stim.push_back('{2, it, 0, o});
    it = mk(24'h000000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h0);
    stim.push_back('{2, it, 0, o});
    it = mk(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    stim.push_back('{2, it, 0, o});
    it = mk(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h0, 24'h0, 24'h0);
    stim.push_back('{2, it, 0, o});

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table
    cur_phase = 0;
    foreach (stim[j]) begin
      if (stim[j].phase != cur_phase) begin
        drain_pipe();
        cur_phase = stim[j].phase;
        if (cur_phase == 1) set_sphere(24'h010000, 24'hFE0000, 24'h008000, 23'h020000,
                                       '0, '0);
        else set_sphere(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF,
                        63'h7FFFFFFFFFFFFFFF, 63'h7FFFFFFFFFFFFFFF);
      end
      send_particle(stim[j].item, stim[j].known, stim[j].exp);
    end

    // random phases, each with a fresh sphere
    for (int ph = 0; ph < 6; ph++) begin
      drain_pipe();
      case (ph)
        0: set_sphere(24'h800000, 24'h800000, 24'h800000, 23'h7FFFFF, rand63(), rand63());
        1: set_sphere(24'($urandom()), 24'($urandom()), 24'($urandom()), 23'h000001,
                      '0, rand63());
        2: set_sphere(24'($urandom()), 24'($urandom()), 24'($urandom()), 23'h000000,
                      rand63(), rand63());
        default: set_sphere(24'($signed($urandom_range(2097151)) - 1048576),
                            24'($signed($urandom_range(2097151)) - 1048576),
                            24'($urandom()),
                            23'($urandom_range(ph == 3 ? 23'h7FFFFF : 23'h040000)),
                            rand63(), rand63());
      endcase
      for (int k = 0; k < 300; k++) begin
        calm = (ph == 4 && k >= 100 && k < 250);
        send_particle(rand_particle(), 1'b0, o);
      end
      calm = 1'b0;
    end

    drain_pipe();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sphere_particle_contact_projection_core.f
rtl/spcp_pkg.sv
rtl/spcp_in_if.sv
rtl/spcp_out_if.sv
rtl/spcp_front.sv
rtl/spcp_sqrt.sv
rtl/spcp_div.sv
rtl/spcp_resp.sv
rtl/sphere_particle_contact_projection_core.sv
test/sphere_particle_contact_projection_core_test.sv
